@@ rtl/shbd_pkg.sv @@
// Shared constants, code table, node ROM builder and interface types of the Huffman byte decoder.
package shbd_pkg;

    // Width of the per-buffer output counter.
    localparam int COUNT_WIDTH = 16;
    // Width of the decode limit register.
    localparam int LIMIT_WIDTH = 16;
    // Width used when comparing the counter against the limit.
    localparam int CMP_WIDTH   = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;

    localparam int NUM_SYMBOLS = 257;
    localparam int ROM_NODES   = 256;
    localparam int MAX_OUT     = 4;
    localparam int NODE_WIDTH  = 8;
    localparam int OUT_IDX_WIDTH = 2;
    localparam int OUT_CNT_WIDTH = 3;

    // Configuration register map (word index taken from the byte address).
    localparam logic REG_OUTPUT_LIMIT = 1'b0;
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 16'hFFFF;

    // ROM entry: bit 10 marks a leaf, bits 8:0 hold the symbol of a leaf,
    // bits 7:0 hold the child node index otherwise, zero means no child.
    typedef logic [10:0] rom_entry_t;
    typedef logic [ROM_NODES-1:0][1:0][10:0] rom_image_t;

    localparam rom_entry_t LEAF_FLAG    = 11'h400;
    localparam logic [8:0] FLUSH_SYMBOL = 9'h100;

    typedef struct packed {
        logic [3:0] len;
        logic [9:0] code;
    } code_entry_t;

    // Fixed prefix code: bit length and code value of each symbol.
    localparam code_entry_t CODE_TABLE [NUM_SYMBOLS] = '{
        '{4'h2, 10'h000}, '{4'h5, 10'h01F}, '{4'h6, 10'h022}, '{4'h7, 10'h034},
        '{4'h7, 10'h075}, '{4'h6, 10'h028}, '{4'h6, 10'h03B}, '{4'h7, 10'h032},
        '{4'h8, 10'h0E0}, '{4'h8, 10'h062}, '{4'h7, 10'h056}, '{4'h8, 10'h079},
        '{4'h9, 10'h19D}, '{4'h8, 10'h097}, '{4'h6, 10'h02A}, '{4'h7, 10'h057},
        '{4'h8, 10'h071}, '{4'h8, 10'h05B}, '{4'h9, 10'h1CC}, '{4'h8, 10'h0A7},
        '{4'h7, 10'h025}, '{4'h7, 10'h04F}, '{4'h8, 10'h066}, '{4'h8, 10'h07D},
        '{4'h9, 10'h191}, '{4'h9, 10'h1CE}, '{4'h7, 10'h03F}, '{4'h9, 10'h090},
        '{4'h8, 10'h059}, '{4'h8, 10'h07B}, '{4'h8, 10'h091}, '{4'h8, 10'h0C6},
        '{4'h6, 10'h02D}, '{4'h9, 10'h186}, '{4'h8, 10'h06F}, '{4'h9, 10'h093},
        '{4'hA, 10'h1CC}, '{4'h8, 10'h05A}, '{4'hA, 10'h1AE}, '{4'hA, 10'h1C0},
        '{4'h9, 10'h148}, '{4'h9, 10'h14A}, '{4'h9, 10'h082}, '{4'hA, 10'h19F},
        '{4'h9, 10'h171}, '{4'h9, 10'h120}, '{4'h9, 10'h0E7}, '{4'hA, 10'h1F3},
        '{4'h9, 10'h14B}, '{4'h9, 10'h100}, '{4'h9, 10'h190}, '{4'h6, 10'h013},
        '{4'h9, 10'h161}, '{4'h9, 10'h125}, '{4'h9, 10'h133}, '{4'h9, 10'h195},
        '{4'h9, 10'h173}, '{4'h9, 10'h1CA}, '{4'h9, 10'h086}, '{4'h9, 10'h1E9},
        '{4'h9, 10'h0DB}, '{4'h9, 10'h1EC}, '{4'h9, 10'h08B}, '{4'h9, 10'h085},
        '{4'h5, 10'h00A}, '{4'h8, 10'h096}, '{4'h8, 10'h09C}, '{4'h9, 10'h1C3},
        '{4'h9, 10'h19C}, '{4'h9, 10'h08F}, '{4'h9, 10'h18F}, '{4'h9, 10'h091},
        '{4'h9, 10'h087}, '{4'h9, 10'h0C6}, '{4'h9, 10'h177}, '{4'h9, 10'h089},
        '{4'h9, 10'h0D6}, '{4'h9, 10'h08C}, '{4'h9, 10'h1EE}, '{4'h9, 10'h1EB},
        '{4'h9, 10'h084}, '{4'h9, 10'h164}, '{4'h9, 10'h175}, '{4'h9, 10'h1CD},
        '{4'h8, 10'h05E}, '{4'h9, 10'h088}, '{4'h9, 10'h12B}, '{4'h9, 10'h172},
        '{4'h9, 10'h10A}, '{4'h9, 10'h08D}, '{4'h9, 10'h13A}, '{4'h9, 10'h11C},
        '{4'hA, 10'h1E1}, '{4'hA, 10'h1E0}, '{4'h9, 10'h187}, '{4'hA, 10'h1DC},
        '{4'hA, 10'h1DF}, '{4'h7, 10'h074}, '{4'h9, 10'h19F}, '{4'h8, 10'h08D},
        '{4'h8, 10'h0E4}, '{4'h7, 10'h079}, '{4'h9, 10'h0EA}, '{4'h9, 10'h0E1},
        '{4'h8, 10'h040}, '{4'h7, 10'h041}, '{4'h9, 10'h10B}, '{4'h9, 10'h0B0},
        '{4'h8, 10'h06A}, '{4'h8, 10'h0C1}, '{4'h7, 10'h071}, '{4'h7, 10'h078},
        '{4'h8, 10'h0B1}, '{4'h9, 10'h14C}, '{4'h7, 10'h043}, '{4'h8, 10'h076},
        '{4'h7, 10'h066}, '{4'h7, 10'h04D}, '{4'h9, 10'h08A}, '{4'h6, 10'h02F},
        '{4'h8, 10'h0C9}, '{4'h9, 10'h0CE}, '{4'h9, 10'h149}, '{4'h9, 10'h160},
        '{4'hA, 10'h1BA}, '{4'hA, 10'h19E}, '{4'hA, 10'h39F}, '{4'h9, 10'h0E5},
        '{4'h9, 10'h194}, '{4'h9, 10'h184}, '{4'h9, 10'h126}, '{4'h7, 10'h030},
        '{4'h8, 10'h06C}, '{4'h9, 10'h121}, '{4'h9, 10'h1E8}, '{4'hA, 10'h1C1},
        '{4'hA, 10'h11D}, '{4'hA, 10'h163}, '{4'hA, 10'h385}, '{4'hA, 10'h3DB},
        '{4'hA, 10'h17D}, '{4'hA, 10'h106}, '{4'hA, 10'h397}, '{4'hA, 10'h24E},
        '{4'h7, 10'h02E}, '{4'h8, 10'h098}, '{4'hA, 10'h33C}, '{4'hA, 10'h32E},
        '{4'hA, 10'h1E9}, '{4'h9, 10'h0BF}, '{4'hA, 10'h3DF}, '{4'hA, 10'h1DD},
        '{4'hA, 10'h32D}, '{4'hA, 10'h2ED}, '{4'hA, 10'h30B}, '{4'hA, 10'h107},
        '{4'hA, 10'h2E8}, '{4'hA, 10'h3DE}, '{4'hA, 10'h125}, '{4'hA, 10'h1E8},
        '{4'h9, 10'h0E9}, '{4'hA, 10'h1CD}, '{4'hA, 10'h1B5}, '{4'h9, 10'h165},
        '{4'hA, 10'h232}, '{4'hA, 10'h2E1}, '{4'hB, 10'h3AE}, '{4'hB, 10'h3C6},
        '{4'hB, 10'h3E2}, '{4'hA, 10'h205}, '{4'hA, 10'h29A}, '{4'hA, 10'h248},
        '{4'hA, 10'h2CD}, '{4'hA, 10'h23B}, '{4'hB, 10'h3C5}, '{4'hA, 10'h251},
        '{4'hA, 10'h2E9}, '{4'hA, 10'h252}, '{4'h9, 10'h1EA}, '{4'hB, 10'h3A0},
        '{4'hB, 10'h391}, '{4'hA, 10'h23C}, '{4'hB, 10'h392}, '{4'hB, 10'h3D5},
        '{4'hA, 10'h233}, '{4'hA, 10'h2CC}, '{4'hB, 10'h390}, '{4'hA, 10'h1BB},
        '{4'hB, 10'h3A1}, '{4'hB, 10'h3C4}, '{4'hA, 10'h211}, '{4'hA, 10'h203},
        '{4'h9, 10'h12A}, '{4'hA, 10'h231}, '{4'hB, 10'h3E0}, '{4'hA, 10'h29B},
        '{4'hB, 10'h3D7}, '{4'hA, 10'h202}, '{4'hB, 10'h3AD}, '{4'hA, 10'h213},
        '{4'hA, 10'h253}, '{4'hA, 10'h32C}, '{4'hA, 10'h23D}, '{4'hA, 10'h23F},
        '{4'hA, 10'h32F}, '{4'hA, 10'h11C}, '{4'hA, 10'h384}, '{4'hA, 10'h31C},
        '{4'hA, 10'h17C}, '{4'hA, 10'h30A}, '{4'hA, 10'h2E0}, '{4'hA, 10'h276},
        '{4'hA, 10'h250}, '{4'hB, 10'h3E3}, '{4'hA, 10'h396}, '{4'hA, 10'h18F},
        '{4'hA, 10'h204}, '{4'hA, 10'h206}, '{4'hA, 10'h230}, '{4'hA, 10'h265},
        '{4'hA, 10'h212}, '{4'hA, 10'h23E}, '{4'hB, 10'h3AC}, '{4'hB, 10'h393},
        '{4'hB, 10'h3E1}, '{4'hA, 10'h1DE}, '{4'hB, 10'h3D6}, '{4'hA, 10'h31D},
        '{4'hB, 10'h3E5}, '{4'hB, 10'h3E4}, '{4'hA, 10'h207}, '{4'hB, 10'h3C7},
        '{4'hA, 10'h277}, '{4'hB, 10'h3D4}, '{4'h8, 10'h0C0}, '{4'hA, 10'h162},
        '{4'hA, 10'h3DA}, '{4'hA, 10'h124}, '{4'hA, 10'h1B4}, '{4'hA, 10'h264},
        '{4'hA, 10'h33D}, '{4'hA, 10'h1D1}, '{4'hA, 10'h1AF}, '{4'hA, 10'h39E},
        '{4'hA, 10'h24F}, '{4'hB, 10'h373}, '{4'hA, 10'h249}, '{4'hB, 10'h372},
        '{4'h9, 10'h167}, '{4'hA, 10'h210}, '{4'hA, 10'h23A}, '{4'hA, 10'h1B8},
        '{4'hB, 10'h3AF}, '{4'hA, 10'h18E}, '{4'hA, 10'h2EC}, '{4'h7, 10'h062},
        '{4'h4, 10'h00D}
    };

    // Builds the node ROM at elaboration by inserting every code into the tree.
    // Conflicting codes are skipped the same way the tree insertion always has.
    // The code is widened to eleven bits so that the longest codes read a zero
    // for their leading bit.
    function automatic rom_image_t build_rom();
        rom_image_t              img;
        int unsigned             nxt;
        int                      k;
        logic [3:0]              len;
        logic [10:0]             code;
        logic [NODE_WIDTH-1:0]   node;
        logic                    bit_v;
        logic                    stop;
        rom_entry_t              c;
        logic [8:0]              sym;
        img = '0;
        nxt = 1;
        for (int s = 0; s < NUM_SYMBOLS; s++) begin
            len  = CODE_TABLE[s].len;
            code = 11'(CODE_TABLE[s].code);
            sym  = 9'(s);
            node = '0;
            stop = 1'b0;
            for (k = int'(len); k > 0; k--) begin
                if (!stop) begin
                    bit_v = code[k-1];
                    c     = img[node][bit_v];
                    if (k == 1) begin
                        if (c == '0) begin
                            img[node][bit_v] = LEAF_FLAG | rom_entry_t'(sym);
                        end
                        stop = 1'b1;
                    end else begin
                        if (c == '0) begin
                            if (nxt >= ROM_NODES) begin
                                stop = 1'b1;
                            end else begin
                                c = rom_entry_t'(nxt);
                                nxt++;
                                img[node][bit_v] = c;
                            end
                        end else if ((c & LEAF_FLAG) != '0) begin
                            stop = 1'b1;
                        end
                        if (!stop) begin
                            node = c[NODE_WIDTH-1:0];
                        end
                    end
                end
            end
        end
        return img;
    endfunction

    localparam rom_image_t NODE_ROM = build_rom();

    // Input transaction payload.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_buffer;
    } s_payload_t;

    // Output transaction payload.
    typedef struct packed {
        logic [7:0] symbol;
        logic       last_in_byte;
    } m_payload_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic emit_adv;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic start_ok;
        logic byte_done;
        logic any_result;
        logic emit_last;
    } dp_status_t;

endpackage

@@ rtl/shbd_ctrl.sv @@
// Controller state machine that sequences load, bit steps and result delivery.
module shbd_ctrl
    import shbd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       m_ready,
    input  dp_status_t sts,
    output ctrl_cmd_t  cmd,
    output logic       s_ready,
    output logic       m_valid
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DECODE = 3'b010,
        ST_EMIT   = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and command decode.
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (sts.start_ok) begin
                        state_next = ST_DECODE;
                    end
                end
            end
            ST_DECODE: begin
                cmd.step = 1'b1;
                if (sts.byte_done) begin
                    state_next = sts.any_result ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.emit_adv = 1'b1;
                    if (sts.emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/shbd_datapath.sv @@
// Datapath: tree walk over the node ROM, output counter and result buffer.
module shbd_datapath
    import shbd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  s_payload_t             s_payload,
    input  logic [LIMIT_WIDTH-1:0] output_limit,
    input  ctrl_cmd_t              cmd,
    output m_payload_t             m_payload,
    output dp_status_t             sts
);

    logic [NODE_WIDTH-1:0]    node_reg,    node_next;
    logic [COUNT_WIDTH-1:0]   count_reg,   count_next;
    logic [7:0]               byte_reg,    byte_next;
    logic [2:0]               bit_cnt_reg, bit_cnt_next;
    logic [OUT_CNT_WIDTH-1:0] n_reg,       n_next;
    logic [OUT_IDX_WIDTH-1:0] idx_reg,     idx_next;
    logic [7:0]               buf_reg [MAX_OUT];

    rom_entry_t               entry;
    logic                     leaf;
    logic                     flush;
    logic                     emit_sym;
    logic                     store_sym;
    logic [COUNT_WIDTH-1:0]   count_inc;
    logic                     reach_limit;
    logic [CMP_WIDTH-1:0]     limit_ext;
    logic [CMP_WIDTH-1:0]     count_cmp;
    logic [CMP_WIDTH-1:0]     count_inc_cmp;
    logic [OUT_CNT_WIDTH-1:0] idx_plus;

    // Child lookup for the current node and the next compressed bit.
    assign entry     = NODE_ROM[node_reg][byte_reg[7]];
    assign leaf      = entry[10];
    assign flush     = leaf && (entry[8:0] == FLUSH_SYMBOL);
    assign emit_sym  = leaf && !flush;
    assign store_sym = emit_sym && (n_reg < OUT_CNT_WIDTH'(MAX_OUT));

    // Saturating counter increment and limit compares.
    assign count_inc     = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    assign limit_ext     = CMP_WIDTH'(output_limit);
    assign count_cmp     = CMP_WIDTH'(count_reg);
    assign count_inc_cmp = CMP_WIDTH'(count_inc);
    assign reach_limit   = count_inc_cmp >= limit_ext;

    // Status for the controller.
    assign idx_plus       = OUT_CNT_WIDTH'(idx_reg) + 1'b1;
    assign sts.start_ok   = s_payload.first_of_buffer ? (limit_ext != '0)
                                                      : (count_cmp < limit_ext);
    assign sts.byte_done  = (bit_cnt_reg == 3'd7) || flush || (emit_sym && reach_limit);
    assign sts.any_result = (n_reg != '0) || emit_sym;
    assign sts.emit_last  = (idx_plus == n_reg);

    // Result fields come straight from the buffer.
    assign m_payload.symbol       = buf_reg[idx_reg];
    assign m_payload.last_in_byte = sts.emit_last;

    // Next-state logic for load, bit step and delivery advance.
    always_comb begin
        node_next    = node_reg;
        count_next   = count_reg;
        byte_next    = byte_reg;
        bit_cnt_next = bit_cnt_reg;
        n_next       = n_reg;
        idx_next     = idx_reg;
        if (cmd.load) begin
            if (s_payload.first_of_buffer) begin
                node_next  = '0;
                count_next = '0;
            end
            byte_next    = s_payload.data_byte;
            bit_cnt_next = '0;
            n_next       = '0;
            idx_next     = '0;
        end else if (cmd.step) begin
            byte_next    = {byte_reg[6:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + 1'b1;
            if (leaf) begin
                node_next = '0;
                if (emit_sym) begin
                    count_next = count_inc;
                    if (store_sym) begin
                        n_next = n_reg + 1'b1;
                    end
                end
            end else begin
                node_next = entry[NODE_WIDTH-1:0];
            end
        end else if (cmd.emit_adv) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_reg    <= '0;
            count_reg   <= '0;
            bit_cnt_reg <= '0;
            n_reg       <= '0;
            idx_reg     <= '0;
        end else begin
            node_reg    <= node_next;
            count_reg   <= count_next;
            bit_cnt_reg <= bit_cnt_next;
            n_reg       <= n_next;
            idx_reg     <= idx_next;
        end
    end

    // Payload registers: the byte shifter and the result buffer.
    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        if (cmd.step && store_sym) begin
            buf_reg[n_reg[OUT_IDX_WIDTH-1:0]] <= entry[7:0];
        end
    end

endmodule

@@ rtl/static_huffman_byte_decoder.sv @@
// Top level of the static Huffman byte decoder with its APB register.
//
//  Port group   Direction  Handshake          Payload
//  s_*          in         s_valid / s_ready  s_payload (data_byte, first_of_buffer)
//  m_*          out        m_valid / m_ready  m_payload (symbol, last_in_byte)
//  APB          in/out     psel / penable     output_limit at byte address 0
//
// A byte is accepted, then walked through the node ROM lookup one compressed bit at
// a time (at most eight), then its decoded symbols go out in order on the result side.
// A byte that decodes nothing returns to idle after its bit steps; a byte arriving
// with the buffer limit already reached returns at once.
// The input is ready only while idle; a stalled result holds the block in delivery.
// Reset is synchronous: root node, zero count, limit 65535.
module static_huffman_byte_decoder
    import shbd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  s_payload_t  s_payload,
    output logic        m_valid,
    input  logic        m_ready,
    output m_payload_t  m_payload,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [LIMIT_WIDTH-1:0] limit_reg;
    logic [LIMIT_WIDTH-1:0] limit_next;
    logic                   cfg_write;
    ctrl_cmd_t              cmd;
    dp_status_t             sts;

    // APB register write and read.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_OUTPUT_LIMIT);
    assign limit_next = cfg_write ? pwdata[LIMIT_WIDTH-1:0] : limit_reg;
    assign prdata    = (paddr[2] == REG_OUTPUT_LIMIT) ? 32'(limit_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else begin
            limit_reg <= limit_next;
        end
    end

    // Sequencer.
    shbd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd),
        .s_ready (s_ready),
        .m_valid (m_valid)
    );

    // Tree walk and result buffer.
    shbd_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_payload    (s_payload),
        .output_limit (limit_reg),
        .cmd          (cmd),
        .m_payload    (m_payload),
        .sts          (sts)
    );

endmodule
